// ===== rtl/circle_through_three_points_top_assert.svh =====
`ifndef CIRCLE_THROUGH_THREE_POINTS_TOP_ASSERT_SVH
`define CIRCLE_THROUGH_THREE_POINTS_TOP_ASSERT_SVH

// checked only out of reset
`define CTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define CTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== rtl/ctp_pkg.sv =====
package ctp_pkg;

  localparam int CoordW   = 16;
  localparam int DiffW    = CoordW + 1;
  localparam int SqW      = 2 * CoordW;
  localparam int EW       = 2 * CoordW + 2;
  localparam int DetW     = 2 * DiffW + 1;
  localparam int AdetW    = DetW - 1;
  localparam int ProdW    = DiffW + EW;
  localparam int MinDetW  = 34;
  localparam int CenterW  = 40;
  localparam int RadiusW  = 40;
  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 4;

  localparam logic RegMinDet = 1'b0;
  localparam logic [MinDetW-1:0] MinDetReset = 34'd1;
  localparam logic signed [CenterW-1:0] CenterMax = 40'sh7F_FFFF_FFFF;
  localparam logic signed [CenterW-1:0] CenterMin = 40'sh80_0000_0000;
  localparam logic [RadiusW-1:0] RadiusMax = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    StValid     = 2'd0,
    StCollinear = 2'd1,
    StSaturated = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic signed [CoordW-1:0] third_x;
    logic signed [CoordW-1:0] third_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CenterW-1:0] center_x;
    logic signed [CenterW-1:0] center_y;
    logic [RadiusW-1:0]        radius;
    status_e                   status;
  } out_item_t;

  typedef struct packed {
    logic signed [DiffW-1:0]  a;
    logic signed [DiffW-1:0]  b;
    logic signed [DiffW-1:0]  c;
    logic signed [DiffW-1:0]  d;
    logic signed [EW-1:0]     e;
    logic signed [EW-1:0]     f;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic                     det_neg;
    logic [AdetW-1:0]         adet;
    logic                     coll;
  } front_rec_t;

endpackage

// ===== rtl/ctp_front.sv =====
module ctp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctp_pkg::in_item_t            item_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [ctp_pkg::MinDetW-1:0]  min_det_i,
  output logic                         q_wr_o,
  output ctp_pkg::front_rec_t          q_wdata_o,
  input  logic                         q_full_i
);
  import ctp_pkg::*;

  logic en;
  logic s1_v_q, s2_v_q;

  logic signed [CoordW-1:0] x1, y1, x2, y2, x3, y3;

  logic signed [DiffW-1:0]  s1_a_q, s1_b_q, s1_c_q, s1_d_q;
  logic signed [SqW-1:0]    s1_sx1_q, s1_sx2_q, s1_sx3_q, s1_sy1_q, s1_sy2_q, s1_sy3_q;
  logic signed [CoordW-1:0] s1_x1_q, s1_y1_q;

  logic signed [DiffW-1:0]   s2_a_q, s2_b_q, s2_c_q, s2_d_q;
  logic signed [EW-1:0]      s2_e_q, s2_f_q;
  logic signed [2*DiffW-1:0] s2_bc_q, s2_ad_q;
  logic signed [CoordW-1:0]  s2_x1_q, s2_y1_q;

  logic signed [DetW-1:0] det, adet_w;

  assign x1 = item_i.first_x;
  assign y1 = item_i.first_y;
  assign x2 = item_i.second_x;
  assign y2 = item_i.second_y;
  assign x3 = item_i.third_x;
  assign y3 = item_i.third_y;

  assign en     = !(s2_v_q && q_full_i);
  assign full_o = !en;
  assign q_wr_o = s2_v_q && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= push_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q   <= x1 - x2;
      s1_b_q   <= y1 - y2;
      s1_c_q   <= x1 - x3;
      s1_d_q   <= y1 - y3;
      s1_sx1_q <= x1 * x1;
      s1_sx2_q <= x2 * x2;
      s1_sx3_q <= x3 * x3;
      s1_sy1_q <= y1 * y1;
      s1_sy2_q <= y2 * y2;
      s1_sy3_q <= y3 * y3;
      s1_x1_q  <= x1;
      s1_y1_q  <= y1;

      s2_a_q  <= s1_a_q;
      s2_b_q  <= s1_b_q;
      s2_c_q  <= s1_c_q;
      s2_d_q  <= s1_d_q;
      s2_e_q  <= s1_sx1_q - s1_sx2_q + s1_sy1_q - s1_sy2_q;
      s2_f_q  <= s1_sx1_q - s1_sx3_q + s1_sy1_q - s1_sy3_q;
      s2_bc_q <= s1_b_q * s1_c_q;
      s2_ad_q <= s1_a_q * s1_d_q;
      s2_x1_q <= s1_x1_q;
      s2_y1_q <= s1_y1_q;
    end
  end

  always_comb begin
    det    = s2_bc_q - s2_ad_q;
    adet_w = det[DetW-1] ? -det : det;
    q_wdata_o.a       = s2_a_q;
    q_wdata_o.b       = s2_b_q;
    q_wdata_o.c       = s2_c_q;
    q_wdata_o.d       = s2_d_q;
    q_wdata_o.e       = s2_e_q;
    q_wdata_o.f       = s2_f_q;
    q_wdata_o.x1      = s2_x1_q;
    q_wdata_o.y1      = s2_y1_q;
    q_wdata_o.det_neg = det[DetW-1];
    q_wdata_o.adet    = adet_w[AdetW-1:0];
    // zero determinant is collinear even with a zero threshold
    q_wdata_o.coll    = (det == '0) || (adet_w[AdetW-1:0] < min_det_i);
  end

endmodule

// ===== rtl/ctp_queue.sv =====
`include "circle_through_three_points_top_assert.svh"

module ctp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  ctp_pkg::front_rec_t wdata_i,
  output logic                full_o,
  input  logic                rd_i,
  output ctp_pkg::front_rec_t rdata_o,
  output logic                empty_o
);
  import ctp_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  front_rec_t      mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = count_q == (PtrW+1)'(Depth);
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (rd_i) rptr_q <= rptr_q + 1'b1;
      if (wr_i && !rd_i) begin
        count_q <= count_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

  `CTP_ASSERT(a_no_overflow, wr_i |-> !full_o, "queue written while full")
  `CTP_ASSERT(a_no_underflow, rd_i |-> !empty_o, "queue read while empty")
  `CTP_ASSERT_ALWAYS(a_count_range, count_q <= (PtrW+1)'(Depth), "queue count out of range")

endmodule

// ===== rtl/ctp_div.sv =====
module ctp_div #(
  parameter int NW = 60,
  parameter int DW = 35
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NW-1:0]        dividend_i,
  input  logic [DW-1:0]        divisor_i,
  input  logic                 neg_i,
  output logic signed [NW:0]   quot_o
);

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [NW-1:0] dvd_q [NW];
  logic [DW-1:0] dsr_q [NW];
  logic          neg_q [NW];
  logic signed [NW:0] quot_q;

  // one quotient bit per stage, msb first
  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW-1:0] rem_in, dsr_in;
    logic [NW-1:0] quo_in, dvd_in, quo_nx;
    logic          neg_in, ge;
    logic [DW:0]   sh, diff;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvd_in = dividend_i;
      assign dsr_in = divisor_i;
      assign neg_in = neg_i;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign dvd_in = dvd_q[s-1];
      assign dsr_in = dsr_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    always_comb begin
      sh     = {rem_in, dvd_in[NW-1-s]};
      diff   = sh - {1'b0, dsr_in};
      ge     = sh >= {1'b0, dsr_in};
      quo_nx = quo_in;
      quo_nx[NW-1-s] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        quo_q[s] <= quo_nx;
        dvd_q[s] <= dvd_in;
        dsr_q[s] <= dsr_in;
        neg_q[s] <= neg_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= neg_q[NW-1] ? -$signed({1'b0, quo_q[NW-1]}) : $signed({1'b0, quo_q[NW-1]});
    end
  end

  assign quot_o = quot_q;

endmodule

// ===== rtl/ctp_sqrt.sv =====
module ctp_sqrt #(
  parameter int RW = 63
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW-1:0]   root_o
);

  localparam int RemW = RW + 2;

  logic [RemW-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];

  // one root bit per stage, two radicand bits consumed each
  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RemW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] rad_in;
    logic [RemW+1:0] sh, trial, diff;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_rest
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    always_comb begin
      sh    = {rem_in, rad_in[2*(RW-1-s)+1 -: 2]};
      trial = (RemW+2)'({root_in, 2'b01});
      diff  = sh - trial;
      ge    = sh >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[RemW-1:0] : sh[RemW-1:0];
        root_q[s] <= {root_in[RW-2:0], ge};
        rad_q[s]  <= rad_in;
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// ===== rtl/ctp_back.sv =====
module ctp_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctp_pkg::front_rec_t q_rdata_i,
  input  logic                q_empty_i,
  output logic                q_rd_o,
  input  logic                pop_i,
  output logic                empty_o,
  output ctp_pkg::out_item_t  result_o
);
  import ctp_pkg::*;

  localparam int NumW    = ProdW + 1;
  localparam int DdW     = NumW + FRAC_BITS;
  localparam int QW      = DdW + 1;
  localparam int DxW     = QW + 1;
  localparam int MW      = (DxW > 63) ? 63 : DxW;
  localparam int HalfW   = (MW + 1) / 2;
  localparam int HiW     = MW - HalfW;
  localparam int RW      = MW + 1;
  localparam int DivW    = AdetW + 1;
  localparam int DivLat  = DdW + 1;
  localparam int SideLen = RW + 5;
  localparam int BigLen  = RW + 4;

  typedef struct packed {
    logic signed [CenterW-1:0] cx;
    logic signed [CenterW-1:0] cy;
    logic                      sat;
    logic                      coll;
  } side_t;

  logic en;

  // queue head
  logic signed [DiffW-1:0] ra, rb, rc, rd;
  logic signed [EW-1:0]    re, rf;

  // product stage
  logic                     b0_v_q;
  logic signed [ProdW-1:0]  b0_bf_q, b0_de_q, b0_ce_q, b0_af_q;
  logic signed [CoordW-1:0] b0_x1_q, b0_y1_q;
  logic                     b0_neg_q, b0_coll_q;
  logic [AdetW-1:0]         b0_adet_q;

  // numerator stage
  logic signed [NumW-1:0]   numx, numy;
  logic [NumW-1:0]          magx, magy;
  logic                     b1_v_q, b1_negx_q, b1_negy_q, b1_coll_q;
  logic [DdW-1:0]           b1_dvdx_q, b1_dvdy_q;
  logic [DivW-1:0]          b1_dsr_q;
  logic signed [CoordW-1:0] b1_x1_q, b1_y1_q;

  // alongside the dividers
  logic                     dv_v_q    [DivLat];
  logic                     dv_coll_q [DivLat];
  logic signed [CoordW-1:0] dv_x1_q   [DivLat];
  logic signed [CoordW-1:0] dv_y1_q   [DivLat];

  logic signed [QW-1:0] qx, qy;

  // center and distance stages
  side_t                     side_c0;
  logic signed [QW:0]        dx, dy, c0_dx_q, c0_dy_q;
  logic                      fit_x, fit_y;
  logic [DxW-1:0]            dxa, dya;
  logic                      big_x, big_y;
  logic [MW-1:0]             c1_dxm_q, c1_dym_q;
  logic [2*HiW-1:0]          c2_hhx_q, c2_hhy_q;
  logic [HiW+HalfW-1:0]      c2_hlx_q, c2_hly_q;
  logic [2*HalfW-1:0]        c2_llx_q, c2_lly_q;
  logic [2*MW-1:0]           c3_sqx_q, c3_sqy_q;
  logic [2*RW-1:0]           c4_rad_q;
  logic [RW-1:0]             root;

  side_t side_q [SideLen];
  logic  v_q    [SideLen];
  logic  big_q  [BigLen];

  logic      rsat;
  out_item_t res_d, res_q;
  logic      out_v_q;

  assign en      = !out_v_q || pop_i;
  assign q_rd_o  = en && !q_empty_i;
  assign empty_o = !out_v_q;

  assign ra = q_rdata_i.a;
  assign rb = q_rdata_i.b;
  assign rc = q_rdata_i.c;
  assign rd = q_rdata_i.d;
  assign re = q_rdata_i.e;
  assign rf = q_rdata_i.f;

  always_comb begin
    numx = b0_bf_q - b0_de_q;
    numy = b0_ce_q - b0_af_q;
    magx = numx[NumW-1] ? -numx : numx;
    magy = numy[NumW-1] ? -numy : numy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q  <= 1'b0;
      b1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < DivLat; i++) dv_v_q[i] <= 1'b0;
      for (int i = 0; i < SideLen; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      b0_v_q    <= q_rd_o;
      b1_v_q    <= b0_v_q;
      dv_v_q[0] <= b1_v_q;
      for (int i = 1; i < DivLat; i++) dv_v_q[i] <= dv_v_q[i-1];
      v_q[0] <= dv_v_q[DivLat-1];
      for (int i = 1; i < SideLen; i++) v_q[i] <= v_q[i-1];
      out_v_q <= v_q[SideLen-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_bf_q   <= rb * rf;
      b0_de_q   <= rd * re;
      b0_ce_q   <= rc * re;
      b0_af_q   <= ra * rf;
      b0_x1_q   <= q_rdata_i.x1;
      b0_y1_q   <= q_rdata_i.y1;
      b0_neg_q  <= q_rdata_i.det_neg;
      b0_adet_q <= q_rdata_i.adet;
      b0_coll_q <= q_rdata_i.coll;

      b1_dvdx_q <= DdW'(magx) << FRAC_BITS;
      b1_dvdy_q <= DdW'(magy) << FRAC_BITS;
      b1_negx_q <= numx[NumW-1] ^ b0_neg_q;
      b1_negy_q <= numy[NumW-1] ^ b0_neg_q;
      // divide by twice the determinant
      b1_dsr_q  <= {b0_adet_q, 1'b0};
      b1_x1_q   <= b0_x1_q;
      b1_y1_q   <= b0_y1_q;
      b1_coll_q <= b0_coll_q;

      dv_x1_q[0]   <= b1_x1_q;
      dv_y1_q[0]   <= b1_y1_q;
      dv_coll_q[0] <= b1_coll_q;
      for (int i = 1; i < DivLat; i++) begin
        dv_x1_q[i]   <= dv_x1_q[i-1];
        dv_y1_q[i]   <= dv_y1_q[i-1];
        dv_coll_q[i] <= dv_coll_q[i-1];
      end
    end
  end

  ctp_div #(.NW(DdW), .DW(DivW)) u_div_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (b1_dvdx_q),
    .divisor_i  (b1_dsr_q),
    .neg_i      (b1_negx_q),
    .quot_o     (qx)
  );

  ctp_div #(.NW(DdW), .DW(DivW)) u_div_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (b1_dvdy_q),
    .divisor_i  (b1_dsr_q),
    .neg_i      (b1_negy_q),
    .quot_o     (qy)
  );

  always_comb begin
    logic signed [QW:0] x1e, y1e, qxe, qye;
    x1e   = dv_x1_q[DivLat-1];
    y1e   = dv_y1_q[DivLat-1];
    qxe   = qx;
    qye   = qy;
    fit_x = (&qx[QW-1:CenterW-1]) || !(|qx[QW-1:CenterW-1]);
    fit_y = (&qy[QW-1:CenterW-1]) || !(|qy[QW-1:CenterW-1]);
    side_c0.cx   = fit_x ? qx[CenterW-1:0] : (qx[QW-1] ? CenterMin : CenterMax);
    side_c0.cy   = fit_y ? qy[CenterW-1:0] : (qy[QW-1] ? CenterMin : CenterMax);
    side_c0.sat  = !fit_x || !fit_y;
    side_c0.coll = dv_coll_q[DivLat-1];
    // distance uses the unsaturated center
    dx = (x1e <<< FRAC_BITS) - qxe;
    dy = (y1e <<< FRAC_BITS) - qye;
  end

  assign dxa = c0_dx_q[QW] ? -c0_dx_q : c0_dx_q;
  assign dya = c0_dy_q[QW] ? -c0_dy_q : c0_dy_q;

  if (DxW > 63) begin : g_big
    assign big_x = |dxa[DxW-1:63];
    assign big_y = |dya[DxW-1:63];
  end else begin : g_no_big
    assign big_x = 1'b0;
    assign big_y = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_dx_q <= dx;
      c0_dy_q <= dy;

      c1_dxm_q <= dxa[MW-1:0];
      c1_dym_q <= dya[MW-1:0];

      // squares from half-width partial products
      c2_hhx_q <= c1_dxm_q[MW-1:HalfW] * c1_dxm_q[MW-1:HalfW];
      c2_hlx_q <= c1_dxm_q[MW-1:HalfW] * c1_dxm_q[HalfW-1:0];
      c2_llx_q <= c1_dxm_q[HalfW-1:0] * c1_dxm_q[HalfW-1:0];
      c2_hhy_q <= c1_dym_q[MW-1:HalfW] * c1_dym_q[MW-1:HalfW];
      c2_hly_q <= c1_dym_q[MW-1:HalfW] * c1_dym_q[HalfW-1:0];
      c2_lly_q <= c1_dym_q[HalfW-1:0] * c1_dym_q[HalfW-1:0];

      c3_sqx_q <= ((2*MW)'(c2_hhx_q) << (2*HalfW)) + ((2*MW)'(c2_hlx_q) << (HalfW+1))
                  + (2*MW)'(c2_llx_q);
      c3_sqy_q <= ((2*MW)'(c2_hhy_q) << (2*HalfW)) + ((2*MW)'(c2_hly_q) << (HalfW+1))
                  + (2*MW)'(c2_lly_q);

      c4_rad_q <= (2*RW)'(c3_sqx_q) + (2*RW)'(c3_sqy_q);

      side_q[0] <= side_c0;
      for (int i = 1; i < SideLen; i++) side_q[i] <= side_q[i-1];
      big_q[0] <= big_x || big_y;
      for (int i = 1; i < BigLen; i++) big_q[i] <= big_q[i-1];

      res_q <= res_d;
    end
  end

  ctp_sqrt #(.RW(RW)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (c4_rad_q),
    .root_o (root)
  );

  always_comb begin
    rsat = big_q[BigLen-1] || (|root[RW-1:RadiusW]);
    if (side_q[SideLen-1].coll) begin
      res_d.center_x = '0;
      res_d.center_y = '0;
      res_d.radius   = '0;
      res_d.status   = StCollinear;
    end else begin
      res_d.center_x = side_q[SideLen-1].cx;
      res_d.center_y = side_q[SideLen-1].cy;
      res_d.radius   = rsat ? RadiusMax : root[RadiusW-1:0];
      res_d.status   = (rsat || side_q[SideLen-1].sat) ? StSaturated : StValid;
    end
  end

  assign result_o = res_q;

endmodule

// ===== rtl/circle_through_three_points_top.sv =====
// the square root has min(54 + FRAC_BITS, 63) + 1 pipelined stages, one root bit each
// throughput: one point triple per cycle while results are popped, set by the bit-per-stage dividers and square root
// a full result register stalls the back pipeline; the front keeps filling a 4-beat queue
// reset: async active low, clears all valid flags and the queue, min_determinant back to 1
module circle_through_three_points_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctp_pkg::in_item_t             item_i,
  input  logic                          push,
  output logic                          full,
  output ctp_pkg::out_item_t            result_o,
  output logic                          empty,
  input  logic                          pop,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctp_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ctp_pkg::CfgDataW-1:0]  pwdata,
  output logic [ctp_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import ctp_pkg::*;

  logic [MinDetW-1:0] min_det_q;
  logic               q_wr, q_full, q_rd, q_empty;
  front_rec_t         q_wdata, q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == RegMinDet) ? CfgDataW'(min_det_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_det_q <= MinDetReset;
    end else if (psel && penable && pwrite && pready && (paddr[3] == RegMinDet)) begin
      min_det_q <= pwdata[MinDetW-1:0];
    end
  end

  ctp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .push_i    (push),
    .full_o    (full),
    .min_det_i (min_det_q),
    .q_wr_o    (q_wr),
    .q_wdata_o (q_wdata),
    .q_full_i  (q_full)
  );

  ctp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  ctp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_rdata_i (q_rdata),
    .q_empty_i (q_empty),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o)
  );

endmodule

// ===== test/circle_through_three_points_checker.sv =====
module circle_through_three_points_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctp_pkg::in_item_t             item_i,
  input  logic                          push,
  input  logic                          full,
  input  ctp_pkg::out_item_t            result_o,
  input  logic                          empty,
  input  logic                          pop,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctp_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ctp_pkg::CfgDataW-1:0]  pwdata,
  input  logic                          pready,
  output int                            fail_count,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ctp_pkg::*;

  localparam int RegStride = 8;

  logic [MinDetW-1:0] min_det;
  out_item_t          circles_due[$];

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic signed [CenterW-1:0] clip_center(logic signed [127:0] v,
                                                            inout bit sat);
    if (v > 128'sh7F_FFFF_FFFF) begin
      sat = 1'b1;
      return CenterMax;
    end
    if (v < -128'sh80_0000_0000) begin
      sat = 1'b1;
      return CenterMin;
    end
    return v[CenterW-1:0];
  endfunction

  function automatic out_item_t circle_of(in_item_t p, logic [MinDetW-1:0] thr);
    longint x1, y1, x2, y2, x3, y3, a, b, c, d, e, f, det, adet;
    logic signed [127:0] nx, ny, det_w, qx, qy, dx, dy;
    logic [127:0] sum;
    logic [63:0] root, cand;
    bit sat;
    out_item_t r;
    x1 = p.first_x;  y1 = p.first_y;
    x2 = p.second_x; y2 = p.second_y;
    x3 = p.third_x;  y3 = p.third_y;
    a = x1 - x2; b = y1 - y2; c = x1 - x3; d = y1 - y3;
    e = (x1 * x1 - x2 * x2) + (y1 * y1 - y2 * y2);
    f = (x1 * x1 - x3 * x3) + (y1 * y1 - y3 * y3);
    det = b * c - a * d;
    adet = det < 0 ? -det : det;
    r = '0;
    if (det == 0 || adet < longint'({30'd0, thr})) begin
      r.status = StCollinear;
      return r;
    end
    nx = b * f - d * e;
    ny = c * e - a * f;
    det_w = det;
    // signed divide truncates toward zero
    qx = (nx * 256) / (det_w * 2);
    qy = (ny * 256) / (det_w * 2);
    sat = 1'b0;
    r.center_x = clip_center(qx, sat);
    r.center_y = clip_center(qy, sat);
    dx = x1;
    dy = y1;
    dx = dx * 256 - qx;
    dy = dy * 256 - qy;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx >= 128'sh8000_0000_0000_0000 || dy >= 128'sh8000_0000_0000_0000) begin
      r.radius = RadiusMax;
      sat = 1'b1;
    end else begin
      sum = dx * dx + dy * dy;
      root = '0;
      for (int i = 63; i >= 0; i--) begin
        cand = root | (64'd1 << i);
        if ({64'd0, cand} * {64'd0, cand} <= sum) root = cand;
      end
      if (root > {24'd0, RadiusMax}) begin
        root = {24'd0, RadiusMax};
        sat = 1'b1;
      end
      r.radius = root[RadiusW-1:0];
    end
    r.status = sat ? StSaturated : StValid;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    min_det = MinDetReset;
  end

  assign pending_o = circles_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      min_det = MinDetReset;
      circles_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr / RegStride == RegMinDet)
        min_det = pwdata[MinDetW-1:0];
      if (push && !full) circles_due.push_back(circle_of(item_i, min_det));
      if (pop && !empty) begin
        if (circles_due.size() == 0) begin
          report_mismatch("unexpected result beat, status", result_o.status, -1);
        end else begin
          want = circles_due.pop_front();
          if (result_o.center_x !== want.center_x)
            report_mismatch("center_x", result_o.center_x, want.center_x);
          if (result_o.center_y !== want.center_y)
            report_mismatch("center_y", result_o.center_y, want.center_y);
          if (result_o.radius !== want.radius)
            report_mismatch("radius", result_o.radius, want.radius);
          if (result_o.status !== want.status)
            report_mismatch("status", result_o.status, want.status);
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctp_pkg::*;

  localparam int  Latency    = 134;
  localparam int  CycleLimit = 600000;
  localparam int  RandItems  = 1250;
  localparam logic [MinDetW-1:0] DetTop = 34'h3_FFFF_FFFF;

  logic clk_i, rst_ni;
  in_item_t item_i;
  logic push, full, empty, pop;
  out_item_t result_o;
  logic psel, penable, pwrite, pready;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata, prdata;
  int fail_count, pending;
  int cycles;
  bit send_busy, pop_calm;

  circle_through_three_points_top DUT (
    .clk_i, .rst_ni, .item_i, .push, .full, .result_o, .empty, .pop,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  circle_through_three_points_checker checker_i (
    .clk_i, .rst_ni, .item_i, .push, .full, .result_o, .empty, .pop,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls, with calm stretches
  initial begin
    int gap;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = pop_calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  task automatic send_item(in_item_t it, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
  endtask

  task automatic write_min_det(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic in_item_t triple(int x1, int y1, int x2, int y2, int x3, int y3);
    in_item_t t;
    t.first_x = CoordW'(x1);  t.first_y = CoordW'(y1);
    t.second_x = CoordW'(x2); t.second_y = CoordW'(y2);
    t.third_x = CoordW'(x3);  t.third_y = CoordW'(y3);
    return t;
  endfunction

  function automatic int coord(int span);
    if (span >= 32768) return $urandom_range(0, 65535) - 32768;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic in_item_t random_triple();
    int kind, span, x1, y1, dx, dy, k;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 3) == 0) ? 32768 : (1 << $urandom_range(2, 14));
    x1 = coord(span);
    y1 = coord(span);
    case (kind)
      0: begin
        // exactly on a line
        dx = coord(span / 4 + 1);
        dy = coord(span / 4 + 1);
        k = $urandom_range(0, 3) - 1;
        return triple(x1, y1, x1 + dx, y1 + dy, x1 + k * dx, y1 + k * dy);
      end
      1, 2: begin
        // almost on a line, small determinant
        dx = coord(span / 4 + 1);
        dy = coord(span / 4 + 1);
        return triple(x1, y1, x1 + dx, y1 + dy,
                      x1 - dx + coord(1), y1 - dy + coord(1));
      end
      3: return triple(x1, y1, x1, y1, coord(span), coord(span));
      default: return triple(x1, y1, coord(span), coord(span), coord(span), coord(span));
    endcase
  endfunction

  initial begin
    in_item_t directed[$];
    logic [MinDetW-1:0] thresholds[5];
    int per_phase, gap_mode;
    rst_ni = 1'b0;
    push = 1'b0;
    item_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pop_calm = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed.push_back(triple(0, 0, 4, 0, 0, 4));
    directed.push_back(triple(5, 5, 5, 5, 5, 5));
    directed.push_back(triple(0, 0, 1, 1, 2, 2));
    directed.push_back(triple(-32768, -32768, -32768, -32768, -32768, -32768));
    directed.push_back(triple(32767, 32767, -32768, -32768, 32767, -32768));
    directed.push_back(triple(-32768, 32767, 32767, -32768, -32768, -32768));
    directed.push_back(triple(-32768, -32768, 32767, 32767, 32767, 32766));
    directed.push_back(triple(-32768, -32768, 32767, 32767, 32766, 32767));
    directed.push_back(triple(-32768, -32768, 32767, 32767, 0, 1));
    directed.push_back(triple(0, 0, 1, 0, 0, 1));
    directed.push_back(triple(1, 0, 0, 1, -1, 0));
    directed.push_back(triple(-7, 3, 11, -9, 2, 14));
    directed.push_back(triple(32767, 0, -32768, 1, 0, -1));
    directed.push_back(triple(-1, -1, 0, 0, 1, 2));
    foreach (directed[i]) send_item(directed[i], $urandom_range(0, 3));

    // other register index is ignored, then sweep thresholds
    write_min_det(4'd8, 64'd12345);
    foreach (directed[i]) send_item(directed[i], 0);

    thresholds[0] = 34'd1;
    thresholds[1] = DetTop;
    thresholds[2] = 34'd2;
    thresholds[3] = 34'd100000;
    thresholds[4] = MinDetW'($urandom_range(1, 1000));
    per_phase = RandItems / 5;
    foreach (thresholds[p]) begin
      write_min_det(4'd0, {30'd0, thresholds[p]});
      for (int n = 0; n < (p == 1 ? 40 : per_phase); n++) begin
        if (n % 60 == 0) begin
          gap_mode = $urandom_range(0, 2);
          pop_calm = ($urandom_range(0, 2) == 0);
        end
        send_item(random_triple(), gap_mode == 0 ? 0 : $urandom_range(0, 19));
      end
    end
    write_min_det(4'd0, 64'd1);
    for (int n = 0; n < per_phase; n++) send_item(random_triple(), $urandom_range(0, 4));

    @(negedge clk_i);
    push <= 1'b0;
    pop_calm = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ctp_pkg.sv
rtl/ctp_front.sv
rtl/ctp_queue.sv
rtl/ctp_div.sv
rtl/ctp_sqrt.sv
rtl/ctp_back.sv
rtl/circle_through_three_points_top.sv
test/circle_through_three_points_checker.sv
test/testbench.sv
